/* rtl/tsac_pkg.sv */
`timescale 1ns / 1ps
// Shared types, register indexes and constants for the touch sample
// averaging and calibration block. No dependencies.
package tsac_pkg;

    localparam int SAMPLE_LOG2 = 2;
    localparam int SAMPLES     = 1 << SAMPLE_LOG2;
    localparam int CNT_W       = 4;
    localparam int SUM_W       = 16;
    localparam int RAW_W       = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int STEPS       = RAW_W;
    localparam int STEP_W      = 4;

    localparam logic [CNT_W-1:0]  LAST_COUNT = CNT_W'(SAMPLES - 1);
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(STEPS - 1);

    localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_FLAGS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_X_OUT_MAX    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OUT_MAX    = 3'd7;

    localparam logic [RAW_W-1:0] RST_RAW_MIN = 12'd300;
    localparam logic [RAW_W-1:0] RST_RAW_MAX = 12'd3800;
    localparam logic [RAW_W-1:0] RST_X_OUT   = 12'd319;
    localparam logic [RAW_W-1:0] RST_Y_OUT   = 12'd239;

    typedef struct packed {
        logic             pen_down;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
    } in_item_t;

    typedef struct packed {
        logic             touched;
        logic [RAW_W-1:0] screen_x;
        logic [RAW_W-1:0] screen_y;
    } out_item_t;

    typedef enum logic [1:0] {
        AX_IDLE,
        AX_CHECK,
        AX_MUL,
        AX_DIV
    } axis_state_t;

    typedef enum logic {
        TS_ACC,
        TS_MAP
    } top_state_t;

endpackage

/* rtl/touch_sample_average_calibrate.sv */
`timescale 1ns / 1ps
// A pen-up item's result is registered and shown in the cycle after acceptance;
// the item completing an average goes through a window check, 12 serial
// multiply steps, 12 serial divide steps and a load of the result register,
// skipping multiply and divide when the window check alone settles it (empty
// window, clamp). Other pen-down items are taken one per cycle while no mapping
// runs; the completing item holds off input while both axis units run in parallel.
// Reset: aresetn synchronous active low; clears sums, count, control and
// loads register reset values. Depends on tsac_pkg and tsac_axis_map.
module touch_sample_average_calibrate (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tsac_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tsac_pkg::out_item_t              m_data,
    input  logic                             cfg_wr_en,
    input  logic [tsac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsac_pkg::RAW_W-1:0]       cfg_data
);
    import tsac_pkg::*;

    top_state_t         state_reg, state_next;
    logic [SUM_W-1:0]   sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]   sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    logic [RAW_W-1:0]   x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [RAW_W-1:0]   x_out_reg, y_out_reg;
    logic               swap_reg;
    logic [1:0]         invert_reg;

    logic               s_fire, last_sample, slot_free, start_map, map_done;
    logic [SUM_W-1:0]   sum_x_add, sum_y_add;
    logic [RAW_W-1:0]   avg_x, avg_y, src_x, src_y;
    logic [RAW_W-1:0]   lo_x, hi_x, lo_y, hi_y, res_x, res_y;
    logic               busy_x, busy_y;

    always_comb begin
        s_fire      = s_valid && s_ready;
        last_sample = count_reg == LAST_COUNT;
        slot_free   = !m_valid_reg || m_ready;
        sum_x_add   = sum_x_reg + SUM_W'(s_data.raw_x);
        sum_y_add   = sum_y_reg + SUM_W'(s_data.raw_y);
        avg_x       = RAW_W'(sum_x_add >> SAMPLE_LOG2);
        avg_y       = RAW_W'(sum_y_add >> SAMPLE_LOG2);
        src_x       = swap_reg ? avg_y : avg_x;
        src_y       = swap_reg ? avg_x : avg_y;
        lo_x        = invert_reg[0] ? x_max_reg : x_min_reg;
        hi_x        = invert_reg[0] ? x_min_reg : x_max_reg;
        lo_y        = invert_reg[1] ? y_max_reg : y_min_reg;
        hi_y        = invert_reg[1] ? y_min_reg : y_max_reg;
        start_map   = s_fire && s_data.pen_down && last_sample;
        map_done    = (state_reg == TS_MAP) && !busy_x && !busy_y && slot_free;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            TS_ACC:  if (start_map) state_next = TS_MAP;
            TS_MAP:  if (map_done) state_next = TS_ACC;
            default: state_next = TS_ACC;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = (state_reg == TS_ACC)
                  && (slot_free || (s_data.pen_down && !last_sample));
        m_valid = m_valid_reg;
        m_data  = m_data_reg;
    end

    // accumulation and result register
    always_comb begin
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        count_next   = count_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (s_fire) begin
            if (!s_data.pen_down || last_sample) begin
                sum_x_next = '0;
                sum_y_next = '0;
                count_next = '0;
            end else begin
                sum_x_next = sum_x_add;
                sum_y_next = sum_y_add;
                count_next = count_reg + 1'b1;
            end
            if (!s_data.pen_down) begin
                m_valid_next = 1'b1;
                m_data_next  = '0;
            end
        end
        if (map_done) begin
            m_valid_next         = 1'b1;
            m_data_next.touched  = 1'b1;
            m_data_next.screen_x = res_x;
            m_data_next.screen_y = res_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= TS_ACC;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            x_min_reg   <= RST_RAW_MIN;
            x_max_reg   <= RST_RAW_MAX;
            y_min_reg   <= RST_RAW_MIN;
            y_max_reg   <= RST_RAW_MAX;
            swap_reg    <= 1'b1;
            invert_reg  <= 2'b00;
            x_out_reg   <= RST_X_OUT;
            y_out_reg   <= RST_Y_OUT;
        end else begin
            state_reg   <= state_next;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_X_RAW_MIN:    x_min_reg  <= cfg_data;
                    REG_X_RAW_MAX:    x_max_reg  <= cfg_data;
                    REG_Y_RAW_MIN:    y_min_reg  <= cfg_data;
                    REG_Y_RAW_MAX:    y_max_reg  <= cfg_data;
                    REG_SWAP_AXES:    swap_reg   <= cfg_data[0];
                    REG_INVERT_FLAGS: invert_reg <= cfg_data[1:0];
                    REG_X_OUT_MAX:    x_out_reg  <= cfg_data;
                    REG_Y_OUT_MAX:    y_out_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
        m_data_reg <= m_data_next;
    end

    tsac_axis_map u_map_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_map),
        .v_in    (src_x),
        .lo_in   (lo_x),
        .hi_in   (hi_x),
        .omax_in (x_out_reg),
        .busy    (busy_x),
        .result  (res_x)
    );

    tsac_axis_map u_map_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_map),
        .v_in    (src_y),
        .lo_in   (lo_y),
        .hi_in   (hi_y),
        .omax_in (y_out_reg),
        .busy    (busy_y),
        .result  (res_y)
    );

    a_no_take_while_mapping: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == TS_MAP |-> !s_ready)
        else $error("input item taken while axes are mapping");

    a_pen_up_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.touched)
        |-> (m_data_reg.screen_x == '0 && m_data_reg.screen_y == '0))
        else $error("untouched item carries coordinates");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LAST_COUNT)
        else $error("sample count past the set size");

    a_map_starts_axes: assert property (@(posedge aclk) disable iff (!aresetn)
        start_map |=> (busy_x && busy_y))
        else $error("axis units did not start");

endmodule

/* rtl/tsac_axis_map.sv */
`timescale 1ns / 1ps
// One axis of the calibration map: bit-serial shift-add multiply followed by
// bit-serial restoring divide, with clamping. Depends on tsac_pkg.
module tsac_axis_map (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [tsac_pkg::RAW_W-1:0] v_in,
    input  logic [tsac_pkg::RAW_W-1:0] lo_in,
    input  logic [tsac_pkg::RAW_W-1:0] hi_in,
    input  logic [tsac_pkg::RAW_W-1:0] omax_in,
    output logic                     busy,
    output logic [tsac_pkg::RAW_W-1:0] result
);
    import tsac_pkg::*;

    axis_state_t              state_reg, state_next;
    logic [RAW_W:0]           d_reg, d_next;
    logic [RAW_W:0]           s_reg, s_next;
    logic [RAW_W-1:0]         omax_reg, omax_next;
    logic [RAW_W-1:0]         as_reg, as_next;
    logic [RAW_W-1:0]         ad_reg, ad_next;
    logic [2*RAW_W-1:0]       p_reg, p_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [RAW_W-1:0]         res_reg, res_next;

    logic [RAW_W:0]           d_abs, s_abs;
    logic                     zero_case, clamp_case;
    logic [RAW_W:0]           mul_sum, div_t, div_r;
    logic                     div_ge, last_step;

    always_comb begin
        d_abs      = d_reg[RAW_W] ? (~d_reg + 1'b1) : d_reg;
        s_abs      = s_reg[RAW_W] ? (~s_reg + 1'b1) : s_reg;
        zero_case  = (s_reg == '0) || (d_reg == '0) || (omax_reg == '0)
                     || (d_reg[RAW_W] != s_reg[RAW_W]);
        clamp_case = d_abs >= s_abs;
        mul_sum    = {1'b0, p_reg[2*RAW_W-1:RAW_W]}
                     + (p_reg[0] ? {1'b0, ad_reg} : '0);
        div_t      = {p_reg[2*RAW_W-1:RAW_W], p_reg[RAW_W-1]};
        div_ge     = div_t >= {1'b0, as_reg};
        div_r      = div_ge ? (div_t - {1'b0, as_reg}) : div_t;
        last_step  = step_reg == LAST_STEP;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            AX_IDLE:  if (start) state_next = AX_CHECK;
            AX_CHECK: state_next = (zero_case || clamp_case) ? AX_IDLE : AX_MUL;
            AX_MUL:   if (last_step) state_next = AX_DIV;
            AX_DIV:   if (last_step) state_next = AX_IDLE;
            default:  state_next = AX_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy   = state_reg != AX_IDLE;
        result = res_reg;
    end

    // datapath
    always_comb begin
        d_next    = d_reg;
        s_next    = s_reg;
        omax_next = omax_reg;
        as_next   = as_reg;
        ad_next   = ad_reg;
        p_next    = p_reg;
        step_next = step_reg;
        res_next  = res_reg;
        unique case (state_reg)
            AX_IDLE: begin
                if (start) begin
                    d_next    = {1'b0, v_in} - {1'b0, lo_in};
                    s_next    = {1'b0, hi_in} - {1'b0, lo_in};
                    omax_next = omax_in;
                end
            end
            AX_CHECK: begin
                ad_next   = d_abs[RAW_W-1:0];
                as_next   = s_abs[RAW_W-1:0];
                p_next    = {{RAW_W{1'b0}}, omax_reg};
                step_next = '0;
                if (zero_case) begin
                    res_next = '0;
                end else if (clamp_case) begin
                    res_next = omax_reg;
                end
            end
            AX_MUL: begin
                p_next    = {mul_sum, p_reg[RAW_W-1:1]};
                step_next = last_step ? '0 : step_reg + 1'b1;
            end
            AX_DIV: begin
                p_next    = {div_r[RAW_W-1:0], p_reg[RAW_W-2:0], div_ge};
                step_next = step_reg + 1'b1;
                if (last_step) begin
                    res_next = {p_reg[RAW_W-2:0], div_ge};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AX_IDLE;
        end else begin
            state_reg <= state_next;
        end
        d_reg    <= d_next;
        s_reg    <= s_next;
        omax_reg <= omax_next;
        as_reg   <= as_next;
        ad_reg   <= ad_next;
        p_reg    <= p_next;
        step_reg <= step_next;
        res_reg  <= res_next;
    end

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == AX_MUL || state_reg == AX_DIV) |-> as_reg != '0)
        else $error("serial divide runs with a zero divisor");

    a_quot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == AX_DIV && last_step) |=> res_reg < omax_reg)
        else $error("quotient not below output maximum");

endmodule
